>>> rtl/pwsa_pkg.sv
// Shared types and constants for the perspective warp source address block.
package pwsa_pkg;

  localparam int COORD_W    = 11;
  localparam int COEF_W     = 32;
  localparam int NUM_COEF   = 8;
  localparam int COEF_IDX_W = $clog2(NUM_COEF);
  localparam int PADDR_W    = COEF_IDX_W + 2;
  localparam int PDATA_W    = 32;

  localparam int FRAC_NUM = 16;
  localparam int FRAC_DEN = 30;

  localparam int PROD_W = COORD_W + 1 + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DEN_W  = PROD_W;
  localparam int MAG_W  = DEN_W - FRAC_NUM;

  localparam int SRC_W      = 12;
  localparam int SRC_WIDTH  = 4096;
  localparam int SRC_HEIGHT = 4096;

  localparam int REM_W  = DEN_W + SRC_W;
  localparam int CMP_W  = MAG_W + FRAC_DEN - SRC_W;
  localparam int DIV_ST = SRC_W + 1;
  localparam int NST    = 3 + DIV_ST + 1;

  localparam logic signed [SUM_W-1:0] DEN_ONE = SUM_W'(1) <<< FRAC_DEN;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [COEF_IDX_W-1:0] {
    REG_COEF_XX       = 3'd0,
    REG_COEF_XY       = 3'd1,
    REG_COEF_X_OFFSET = 3'd2,
    REG_COEF_YX       = 3'd3,
    REG_COEF_YY       = 3'd4,
    REG_COEF_Y_OFFSET = 3'd5,
    REG_PERSP_X       = 3'd6,
    REG_PERSP_Y       = 3'd7
  } coef_idx_t;

  localparam coef_t COEF_RST [NUM_COEF] = '{
    32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0
  };

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             den_ok;
    logic [DEN_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic [SRC_W-1:0] q;
    logic             ok;
  } div_out_t;

endpackage

>>> rtl/pwsa_if.sv
// Item channel interfaces for the input coordinate and the source address result.
interface pwsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [pwsa_pkg::COORD_W-1:0] out_x;
  logic [pwsa_pkg::COORD_W-1:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink (input valid, input out_x, input out_y, output ready);
endinterface

interface pwsa_out_if;
  logic                       valid;
  logic                       ready;
  logic [pwsa_pkg::SRC_W-1:0] src_x;
  logic [pwsa_pkg::SRC_W-1:0] src_y;
  logic                       in_bounds;

  modport source (output valid, output src_x, output src_y, output in_bounds, input ready);
  modport sink (input valid, input src_x, input src_y, input in_bounds, output ready);
endinterface

>>> rtl/pwsa_div.sv
// Pipelined restoring divider lane: range check, then one quotient bit per stage.
module pwsa_div (
  input  logic                         clk,
  input  logic [pwsa_pkg::DIV_ST-1:0]  ld,
  input  pwsa_pkg::div_in_t            din,
  output pwsa_pkg::div_out_t           dout
);
  import pwsa_pkg::*;

  logic [REM_W-1:0] rem_r [DIV_ST];
  logic [DEN_W-1:0] den_r [DIV_ST];
  logic [SRC_W-1:0] q_r   [DIV_ST];
  logic             ok_r  [DIV_ST];
  logic             neg_r [DIV_ST];
  logic [REM_W-1:0] dsh   [DIV_ST-1];
  logic             ovf;

  // quotient >= 2^SRC_W  <=>  mag * 2^(FRAC_DEN - SRC_W) >= den
  assign ovf = (CMP_W'(din.mag) << (FRAC_DEN - SRC_W)) >= CMP_W'(din.den);

  always_comb begin
    for (int j = 1; j < DIV_ST; j++) begin
      dsh[j-1] = REM_W'(den_r[j-1]) << (DIV_ST - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem_r[0] <= REM_W'(din.mag) << FRAC_DEN;
      den_r[0] <= din.den;
      q_r[0]   <= '0;
      ok_r[0]  <= din.den_ok && !ovf;
      neg_r[0] <= din.neg;
    end
    for (int j = 1; j < DIV_ST; j++) begin
      if (ld[j]) begin
        den_r[j] <= den_r[j-1];
        ok_r[j]  <= ok_r[j-1];
        neg_r[j] <= neg_r[j-1];
        if (rem_r[j-1] >= dsh[j-1]) begin
          rem_r[j] <= rem_r[j-1] - dsh[j-1];
          q_r[j]   <= q_r[j-1] | (SRC_W'(1) << (DIV_ST - 1 - j));
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
      end
    end
  end

  // a negative numerator stays in range only when its quotient truncates to zero
  assign dout.q  = q_r[DIV_ST-1];
  assign dout.ok = ok_r[DIV_ST-1] && (!neg_r[DIV_ST-1] || q_r[DIV_ST-1] == '0);

endmodule

>>> rtl/perspective_warp_source_address.sv
// Top level: homography inverse mapping of an output pixel to a source address.
// Takes one output pixel coordinate per clock and returns one source coordinate per
// item, at a sustained rate of one item per cycle while out_item.ready stays high. There
// are 17 register stages: one stage of products, one of sums, one of magnitude, a range
// check and twelve restoring-division stages (one quotient bit each, two lanes for x and
// y), then the output register. Every stage stalls only when the stage after it is full,
// so bubbles close up under backpressure. The eight coefficients sit on an APB port at
// byte address 4*i; write them only while no item is in flight.
module perspective_warp_source_address (
  input  logic                          clk,
  input  logic                          rst_n,
  pwsa_in_if.sink                       in_item,
  pwsa_out_if.source                    out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [pwsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [pwsa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pwsa_pkg::*;

  function automatic logic signed [PROD_W-1:0] mul_cc(input logic [COORD_W-1:0] c,
                                                      input coef_t h);
    logic signed [PROD_W-1:0] ce;
    logic signed [PROD_W-1:0] he;
    ce = PROD_W'($signed({1'b0, c}));
    he = PROD_W'(h);
    return ce * he;
  endfunction

  coef_t coef_r [NUM_COEF];

  logic [NST-1:0] valid_r;
  logic [NST-1:0] rdy;

  logic signed [PROD_W-1:0] pdx_r, pdy_r, pnxx_r, pnxy_r, pnyx_r, pnyy_r;
  logic signed [SUM_W-1:0]  den_r, nx_r, ny_r;
  logic signed [SUM_W-1:0]  den_nxt, nx_nxt, ny_nxt;
  logic [SUM_W-1:0]         ax, ay;
  logic                     den_ok;
  div_in_t                  dx_r, dy_r;
  div_out_t                 qx, qy;
  logic [SRC_W-1:0]         src_x_r, src_y_r;
  logic                     inb_r;
  logic                     inb_nxt;
  logic                     cfg_wr;
  logic [COEF_IDX_W-1:0]    cfg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign prdata  = PDATA_W'(coef_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= COEF_RST[i];
    end else if (cfg_wr) begin
      coef_r[cfg_idx] <= coef_t'(pwdata);
    end
  end

  // stall chain
  always_comb begin
    rdy[NST-1] = !valid_r[NST-1] || out_item.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_item.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) valid_r[0] <= in_item.valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // stage 0: products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pdx_r  <= mul_cc(in_item.out_x, coef_r[REG_PERSP_X]);
      pdy_r  <= mul_cc(in_item.out_y, coef_r[REG_PERSP_Y]);
      pnxx_r <= mul_cc(in_item.out_x, coef_r[REG_COEF_XX]);
      pnxy_r <= mul_cc(in_item.out_y, coef_r[REG_COEF_XY]);
      pnyx_r <= mul_cc(in_item.out_x, coef_r[REG_COEF_YX]);
      pnyy_r <= mul_cc(in_item.out_y, coef_r[REG_COEF_YY]);
    end
  end

  // stage 1: sums
  assign den_nxt = SUM_W'(pdx_r) + SUM_W'(pdy_r) + DEN_ONE;
  assign nx_nxt  = SUM_W'(pnxx_r) + SUM_W'(pnxy_r) + SUM_W'(coef_r[REG_COEF_X_OFFSET]);
  assign ny_nxt  = SUM_W'(pnyx_r) + SUM_W'(pnyy_r) + SUM_W'(coef_r[REG_COEF_Y_OFFSET]);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      den_r <= den_nxt;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
    end
  end

  // stage 2: numerator magnitude, truncated to whole pixels
  always_comb begin
    ax     = nx_r[SUM_W-1] ? SUM_W'(-nx_r) : SUM_W'(nx_r);
    ay     = ny_r[SUM_W-1] ? SUM_W'(-ny_r) : SUM_W'(ny_r);
    den_ok = !den_r[SUM_W-1] && (den_r != '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dx_r.mag    <= ax[DEN_W-1:FRAC_NUM];
      dx_r.neg    <= nx_r[SUM_W-1];
      dx_r.den_ok <= den_ok;
      dx_r.den    <= den_r[DEN_W-1:0];
      dy_r.mag    <= ay[DEN_W-1:FRAC_NUM];
      dy_r.neg    <= ny_r[SUM_W-1];
      dy_r.den_ok <= den_ok;
      dy_r.den    <= den_r[DEN_W-1:0];
    end
  end

  // stages 3 .. 3+DIV_ST-1: division lanes
  pwsa_div u_div_x (
    .clk  (clk),
    .ld   (rdy[3 +: DIV_ST]),
    .din  (dx_r),
    .dout (qx)
  );

  pwsa_div u_div_y (
    .clk  (clk),
    .ld   (rdy[3 +: DIV_ST]),
    .din  (dy_r),
    .dout (qy)
  );

  // output register
  assign inb_nxt = qx.ok && qy.ok &&
                   ({1'b0, qx.q} < (SRC_W + 1)'(SRC_WIDTH)) &&
                   ({1'b0, qy.q} < (SRC_W + 1)'(SRC_HEIGHT));

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      inb_r   <= inb_nxt;
      src_x_r <= inb_nxt ? qx.q : '0;
      src_y_r <= inb_nxt ? qy.q : '0;
    end
  end

  assign out_item.valid     = valid_r[NST-1];
  assign out_item.src_x     = src_x_r;
  assign out_item.src_y     = src_y_r;
  assign out_item.in_bounds = inb_r;

  logic in_acc, out_acc;
  assign in_acc  = in_item.valid && in_item.ready;
  assign out_acc = out_item.valid && out_item.ready;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_acc |=> $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("pipeline occupancy did not grow on accept");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc && out_acc |=> $countones(valid_r) + 1 == $past($countones(valid_r)))
    else $error("pipeline occupancy did not shrink on delivery");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> valid_r[NST-1] && !out_item.ready && (&valid_r))
    else $error("input stalled with room in the pipeline");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && !out_item.in_bounds |-> src_x_r == '0 && src_y_r == '0)
    else $error("out of bounds result carries a nonzero address");

endmodule
